// ----- rtl/hkrb_pkg.sv -----
// ---------------------------------------------------------------------------
// hkrb_pkg
// Shared types and constants for the keyboard report builder.
// ---------------------------------------------------------------------------
package hkrb_pkg;

  typedef enum logic [1:0] {
    OP_PRESS       = 2'd0,
    OP_RELEASE     = 2'd1,
    OP_RELEASE_ALL = 2'd2
  } op_e;

  localparam logic [7:0] MOD_FIRST = 8'hE0;
  localparam logic [7:0] MOD_LAST  = 8'hE7;
  localparam logic [7:0] REPORT_ID = 8'h01;
  localparam logic [7:0] RESERVED  = 8'h00;

  // Control broadcast to every slot cell
  typedef struct packed {
    logic shift;  // take the neighbour's value
    logic clear;  // release all: zero the slot
  } cell_ctrl_t;

endpackage

// ----- rtl/hkrb_cell.sv -----
// ---------------------------------------------------------------------------
// hkrb_cell
// One key-code slot of the rotating slot chain.
// ---------------------------------------------------------------------------
module hkrb_cell
  import hkrb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic [7:0] data_i,
  output logic [7:0] data_o
);

  logic [7:0] slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= 8'h00;
    end else if (ctrl_i.clear) begin
      slot_q <= 8'h00;
    end else if (ctrl_i.shift) begin
      slot_q <= data_i;
    end
  end

  assign data_o = slot_q;

endmodule

// ----- rtl/hid_keyboard_report_builder_unit.sv -----
// ---------------------------------------------------------------------------
// hid_keyboard_report_builder_unit
// Keyboard state (modifier mask plus key-code slots) updated per key event,
// with the full report streamed out one byte per beat after each event.
// ---------------------------------------------------------------------------
//
//   channel | signals                                  | dir | beat
//   --------+------------------------------------------+-----+-----------------
//   in      | in_valid_i in_ready_o operation_i key_i  | in  | one key event
//   out     | out_valid_o out_ready_i report_byte_o    | out | one report byte
//           | last_byte_o                              |     |
//
// Each event gives KEY_SLOTS + 3 output beats (9 at the default), one byte
// per cycle when the sink keeps ready high; that figure is set by the single
// output register, which the slot chain feeds once per byte.
// A new event is taken as soon as the last byte of the report is in the
// output register, while that byte may still wait for the sink.
// Reset zeroes the mask and every slot at once; no clearing pass.
// A stalled sink holds the output register and freezes the chain.
// ---------------------------------------------------------------------------
module hid_keyboard_report_builder_unit
  import hkrb_pkg::*;
#(
  parameter int KEY_SLOTS = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] key_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] report_byte_o,
  output logic       last_byte_o
);

  localparam int LEN   = KEY_SLOTS + 3;
  localparam int IDX_W = $clog2(LEN);

  localparam logic [IDX_W-1:0] IDX_ID    = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_MOD   = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_RSVD  = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(LEN - 1);

  // Sequencer state
  logic             busy_q, busy_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             done_q, done_d;   // slot part of the event already applied
  logic [1:0]       op_q;
  logic [7:0]       key_q;
  logic [7:0]       mod_q, mod_d;

  // Output register
  logic             out_valid_q, out_valid_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;

  logic             in_acc;
  logic             load;
  logic             in_is_mod;
  logic [7:0]       mod_bit;
  logic [7:0]       head;
  logic [7:0]       slot_new;
  logic             slot_hit;
  logic             slot_phase;
  cell_ctrl_t       cell_ctrl;
  logic [7:0]       slot_w [KEY_SLOTS];

  assign in_ready_o = !busy_q;
  assign in_acc     = in_valid_i && in_ready_o;
  // a byte goes into the output register when it is free or being emptied
  assign load       = busy_q && (!out_valid_q || out_ready_i);
  assign slot_phase = (idx_q >= IDX_FIRST);

  assign in_is_mod  = (key_i >= MOD_FIRST) && (key_i <= MOD_LAST);
  assign mod_bit    = 8'h01 << key_i[2:0];

  // Slot chain: head cell is examined, the result rotates in at the tail
  assign cell_ctrl.shift = load && slot_phase;
  assign cell_ctrl.clear = in_acc && (op_e'(operation_i) == OP_RELEASE_ALL);

  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_cell
    logic [7:0] nb;
    if (i == KEY_SLOTS - 1) begin : g_tail
      assign nb = slot_new;
    end else begin : g_mid
      assign nb = slot_w[i+1];
    end
    hkrb_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .data_i (nb),
      .data_o (slot_w[i])
    );
  end

  assign head = slot_w[0];

  // Press fills the first empty slot, release empties the first match
  always_comb begin
    slot_new = head;
    slot_hit = 1'b0;
    priority if (!done_q && (op_e'(op_q) == OP_PRESS) && (head == 8'h00)) begin
      slot_new = key_q;
      slot_hit = 1'b1;
    end else if (!done_q && (op_e'(op_q) == OP_RELEASE) && (head == key_q)) begin
      slot_new = 8'h00;
      slot_hit = 1'b1;
    end else begin
      slot_new = head;
      slot_hit = 1'b0;
    end
  end

  always_comb begin
    busy_d      = busy_q;
    idx_d       = idx_q;
    done_d      = done_q;
    mod_d       = mod_q;
    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    last_d      = last_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (in_acc) begin
      busy_d = 1'b1;
      idx_d  = IDX_ID;
      // modifiers and the unused code touch no slot
      done_d = in_is_mod || !((op_e'(operation_i) == OP_PRESS) ||
                              (op_e'(operation_i) == OP_RELEASE));
      case (op_e'(operation_i))
        OP_PRESS: begin
          if (in_is_mod) mod_d = mod_q | mod_bit;
        end
        OP_RELEASE: begin
          if (in_is_mod) mod_d = mod_q & ~mod_bit;
        end
        OP_RELEASE_ALL: begin
          mod_d = 8'h00;
        end
        default: begin
          mod_d = mod_q;
        end
      endcase
    end

    if (load) begin
      out_valid_d = 1'b1;
      last_d      = (idx_q == IDX_LAST);
      priority if (idx_q == IDX_ID) begin
        byte_d = REPORT_ID;
      end else if (idx_q == IDX_MOD) begin
        byte_d = mod_q;
      end else if (idx_q == IDX_RSVD) begin
        byte_d = RESERVED;
      end else begin
        byte_d = slot_new;
        if (slot_hit) done_d = 1'b1;
      end
      if (idx_q == IDX_LAST) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= IDX_ID;
      done_q      <= 1'b1;
      mod_q       <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      done_q      <= done_d;
      mod_q       <= mod_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    if (in_acc) begin
      op_q  <= operation_i;
      key_q <= key_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign report_byte_o = byte_q;
  assign last_byte_o   = last_q;

  // Assertions

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (busy_q && (idx_q == IDX_ID)))
    else $error("event accepted but report not started");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q <= IDX_LAST))
    else $error("byte index beyond report length");

  a_id_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (idx_q == IDX_ID)) |=> (out_valid_o && (report_byte_o == REPORT_ID)
                                     && !last_byte_o))
    else $error("report does not open with its id");

  // a waiting last byte may overlap only a next event that has not begun
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_byte_o) |-> (!busy_q || (idx_q == IDX_ID)))
    else $error("last byte shown while report still being built");

endmodule
